### design/mppt_pso_and_perturb_observe_unit_defines.svh
// Assertion macros for the maximum power point tracker.
// Each use sits in a module that has clk and arst_n.
`ifndef MPPT_PSO_AND_PERTURB_OBSERVE_UNIT_DEFINES_SVH
`define MPPT_PSO_AND_PERTURB_OBSERVE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define MPPO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mppo assertion failed");

`define MPPO_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mppo assertion failed");

`define MPPO_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mppo assertion failed");

`else

`define MPPO_ASSERT(lbl, prop)
`define MPPO_ASSERT_IMP(lbl, ante, cons)
`define MPPO_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### design/mppo_pkg.sv
`timescale 1ns / 1ps
package mppo_pkg;

	localparam int NUM_PARTICLES = 5;
	localparam int PIDX_W = $clog2(NUM_PARTICLES);
	localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(NUM_PARTICLES - 1);

	// spread: vmin + floor(span * (2i+1) / (2N))
	localparam int SPREAD_DIV = 2 * NUM_PARTICLES;
	localparam int SPAN_X_W = 16 + PIDX_W + 1;
	localparam int PROD_W = SPAN_X_W + 32;
	localparam logic [31:0] SPREAD_RECIP = 32'((64'd1 << 32) / SPREAD_DIV);

	localparam logic [2:0] CFG_ALGO       = 3'd0;
	localparam logic [2:0] CFG_VOUT_MIN   = 3'd1;
	localparam logic [2:0] CFG_VOUT_MAX   = 3'd2;
	localparam logic [2:0] CFG_PO_STEP    = 3'd3;
	localparam logic [2:0] CFG_TRACK_STEP = 3'd4;
	localparam logic [2:0] CFG_VEL_LIMIT  = 3'd5;
	localparam logic [2:0] CFG_MAX_ITER   = 3'd6;
	localparam logic [2:0] CFG_RNG_SEED   = 3'd7;

	localparam logic [1:0] PHASE_PO    = 2'd0;
	localparam logic [1:0] PHASE_SCAN  = 2'd1;
	localparam logic [1:0] PHASE_TRACK = 2'd2;

	localparam logic [15:0] PO_START_VREF = 16'd15462;
	localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
	localparam logic signed [32:0] FIT_NONE = -33'sd1;

	typedef struct packed {
		logic cap;
		logic mul;
		logic po_restart;
		logic po_step;
		logic spr_x;
		logic spr_q;
		logic spr_wr;
		logic spr_fin;
		logic scan_eval;
		logic upd_a;
		logic upd_b;
		logic scan_chk;
		logic track;
		logic load_out;
		logic warm;
		logic [PIDX_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic algo;
		logic ready;
		logic in_track;
		logic wrap;
		logic drop;
	} dp_status_t;

	function automatic logic [15:0] clamp_ref(input logic signed [19:0] x,
		input logic [15:0] lo, input logic [15:0] hi);
		logic signed [19:0] lo_s;
		logic signed [19:0] hi_s;
		lo_s = $signed({4'b0, lo});
		hi_s = $signed({4'b0, hi});
		if (x < lo_s) return lo;
		else if (x > hi_s) return hi;
		else return x[15:0];
	endfunction

	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		if (v[0]) return {1'b0, v[31:1]} ^ LFSR_TAPS;
		else return {1'b0, v[31:1]};
	endfunction

endpackage

### design/mppo_datapath.sv
`timescale 1ns / 1ps
module mppo_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mppo_pkg::dp_cmd_t      cmd,
	output mppo_pkg::dp_status_t   status,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   op,
	input  logic [15:0]            pv_voltage,
	input  logic [15:0]            pv_current,
	output logic [15:0]            vref,
	output logic [31:0]            power,
	output logic [1:0]             phase
);

	localparam int NP = mppo_pkg::NUM_PARTICLES;
	localparam int SXW = mppo_pkg::SPAN_X_W;
	localparam int PW = mppo_pkg::PROD_W;
	localparam logic [SXW-1:0] DIV_C = SXW'(mppo_pkg::SPREAD_DIV);

	// configuration
	logic        algo_q;
	logic [15:0] vmin_q, vmax_q;
	logic [12:0] po_step_q;
	logic [9:0]  track_step_q;
	logic [13:0] vel_limit_q;
	logic [7:0]  max_iter_q;
	logic [31:0] seed_q;

	logic        op_q;
	logic [15:0] volt_q, curr_q;
	logic [31:0] power_q;

	logic [31:0] po_prev_q;
	logic [15:0] po_vref_q;
	logic        po_down_q;

	logic [15:0]        pos_q [NP];
	logic signed [14:0] vel_q [NP];
	logic [15:0]        pbest_pos_q [NP];
	logic signed [32:0] pbest_fit_q [NP];
	logic [15:0]        gbest_pos_q;
	logic signed [32:0] gbest_fit_q;
	logic [mppo_pkg::PIDX_W-1:0] pidx_q;
	logic [7:0]         cyc_q;
	logic               in_track_q;
	logic signed [32:0] ref_pow_q;
	logic               track_down_q;
	logic signed [32:0] tprev_q;
	logic [15:0]        tvref_q;
	logic               ready_q;
	logic [31:0]        lfsr_q;

	logic [SXW-1:0]     sx_q, sq_q;
	logic signed [17:0] t1_q, t2_q;

	logic [15:0] vref_q;
	logic [31:0] power_out_q;
	logic [1:0]  phase_q;

	logic signed [32:0] p_s;
	logic [15:0]        span;
	logic [SXW-1:0]     span_x;
	logic [PW-1:0]      recip_prod;
	logic [SXW-1:0]     spr_rem, spr_fix;
	logic [15:0]        spr_pos;
	logic [31:0]        r1, r2;
	logic signed [16:0] d1, d2, nd1, nd2;
	logic [15:0]        mag1, mag2;
	logic [47:0]        prod1, prod2;
	logic [16:0]        m1, m2;
	logic signed [17:0] t1, t2;
	logic signed [14:0] vel_half;
	logic signed [19:0] vsum, vlim, vsat;
	logic [15:0]        upd_pos;
	logic [15:0]        p0_new;
	logic               po_down_n, track_down_n;
	logic [15:0]        po_vref_n, tvref_n;
	logic signed [40:0] ref_ext, drop_diff, drop_lhs, drop_rhs;
	logic               drop;
	logic               iter_done;

	always_comb begin
		p_s = $signed({1'b0, power_q});
		span = (vmax_q > vmin_q) ? vmax_q - vmin_q : 16'd0;
		span_x = SXW'(span) * SXW'({cmd.idx, 1'b1});
		recip_prod = {32'b0, sx_q} * {{SXW{1'b0}}, mppo_pkg::SPREAD_RECIP};
		// estimate is at most one short
		spr_rem = sx_q - sq_q * DIV_C;
		spr_fix = (spr_rem >= DIV_C) ? sq_q + SXW'(1) : sq_q;
		spr_pos = vmin_q + spr_fix[15:0];

		r1 = mppo_pkg::lfsr_next(lfsr_q);
		r2 = mppo_pkg::lfsr_next(r1);
		d1 = $signed({1'b0, pbest_pos_q[cmd.idx]}) - $signed({1'b0, pos_q[cmd.idx]});
		d2 = $signed({1'b0, gbest_pos_q}) - $signed({1'b0, pos_q[cmd.idx]});
		nd1 = -d1;
		nd2 = -d2;
		mag1 = d1[16] ? nd1[15:0] : d1[15:0];
		mag2 = d2[16] ? nd2[15:0] : d2[15:0];
		prod1 = {32'b0, mag1} * {16'b0, r1};
		prod2 = {32'b0, mag2} * {16'b0, r2};
		m1 = prod1[47:31];
		m2 = prod2[47:31];
		t1 = d1[16] ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
		t2 = d2[16] ? -$signed({1'b0, m2}) : $signed({1'b0, m2});

		// halve towards zero
		vel_half = (vel_q[cmd.idx] + $signed({14'b0, vel_q[cmd.idx][14]})) >>> 1;
		vsum = $signed({{5{vel_half[14]}}, vel_half}) + $signed({{2{t1_q[17]}}, t1_q})
			+ $signed({{2{t2_q[17]}}, t2_q});
		vlim = $signed({6'b0, vel_limit_q});
		if (vsum > vlim) vsat = vlim;
		else if (vsum < -vlim) vsat = -vlim;
		else vsat = vsum;
		upd_pos = mppo_pkg::clamp_ref($signed({4'b0, pos_q[cmd.idx]}) + vsat, vmin_q, vmax_q);

		p0_new = (cmd.warm && gbest_fit_q > 33'sd0)
			? mppo_pkg::clamp_ref($signed({4'b0, gbest_pos_q}), vmin_q, vmax_q) : pos_q[0];

		po_down_n = (power_q <= po_prev_q) ? ~po_down_q : po_down_q;
		po_vref_n = mppo_pkg::clamp_ref(po_down_n
			? $signed({4'b0, po_vref_q}) - $signed({7'b0, po_step_q})
			: $signed({4'b0, po_vref_q}) + $signed({7'b0, po_step_q}), vmin_q, vmax_q);

		track_down_n = (!tprev_q[32] && p_s < tprev_q) ? ~track_down_q : track_down_q;
		tvref_n = mppo_pkg::clamp_ref(track_down_n
			? $signed({4'b0, tvref_q}) - $signed({10'b0, track_step_q})
			: $signed({4'b0, tvref_q}) + $signed({10'b0, track_step_q}), vmin_q, vmax_q);

		// (ref - p) * 20 > ref * 3
		ref_ext = $signed({{8{ref_pow_q[32]}}, ref_pow_q});
		drop_diff = ref_ext - $signed({8'b0, p_s});
		drop_lhs = (drop_diff <<< 4) + (drop_diff <<< 2);
		drop_rhs = (ref_ext <<< 1) + ref_ext;
		drop = (ref_pow_q > 33'sd0) && (drop_lhs > drop_rhs);

		iter_done = cyc_q >= max_iter_q;
	end

	assign status.op = op_q;
	assign status.algo = algo_q;
	assign status.ready = ready_q;
	assign status.in_track = in_track_q;
	assign status.wrap = pidx_q == mppo_pkg::LAST_IDX;
	assign status.drop = drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algo_q <= 1'b0;
			vmin_q <= 16'd5120;
			vmax_q <= 16'd23552;
			po_step_q <= 13'd1024;
			track_step_q <= 10'd41;
			vel_limit_q <= 14'd3686;
			max_iter_q <= 8'd10;
			seed_q <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mppo_pkg::CFG_ALGO:       algo_q <= cfg_data[0];
				mppo_pkg::CFG_VOUT_MIN:   vmin_q <= cfg_data[15:0];
				mppo_pkg::CFG_VOUT_MAX:   vmax_q <= cfg_data[15:0];
				mppo_pkg::CFG_PO_STEP:    po_step_q <= cfg_data[12:0];
				mppo_pkg::CFG_TRACK_STEP: track_step_q <= cfg_data[9:0];
				mppo_pkg::CFG_VEL_LIMIT:  vel_limit_q <= cfg_data[13:0];
				mppo_pkg::CFG_MAX_ITER:   max_iter_q <= cfg_data[7:0];
				mppo_pkg::CFG_RNG_SEED:   seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			po_prev_q <= '0;
			po_vref_q <= mppo_pkg::PO_START_VREF;
			po_down_q <= 1'b0;
			ready_q <= 1'b0;
			in_track_q <= 1'b0;
			pidx_q <= '0;
			cyc_q <= '0;
			lfsr_q <= 32'd1;
		end else begin
			if (cmd.po_restart) begin
				po_prev_q <= '0;
				po_vref_q <= mppo_pkg::PO_START_VREF;
				po_down_q <= 1'b0;
			end
			if (cmd.po_step) begin
				po_prev_q <= power_q;
				po_vref_q <= po_vref_n;
				po_down_q <= po_down_n;
			end
			if (cmd.spr_fin) begin
				pidx_q <= '0;
				cyc_q <= '0;
				in_track_q <= 1'b0;
				if (!cmd.warm) begin
					ready_q <= 1'b1;
					lfsr_q <= (seed_q != 32'd0) ? seed_q : 32'd1;
				end
			end
			if (cmd.scan_eval) begin
				if (status.wrap) begin
					pidx_q <= '0;
					if (cyc_q != 8'd255) cyc_q <= cyc_q + 8'd1;
				end else begin
					pidx_q <= pidx_q + mppo_pkg::PIDX_W'(1);
				end
			end
			if (cmd.upd_a) lfsr_q <= r2;
			if (cmd.scan_chk && iter_done) in_track_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q <= op;
			volt_q <= pv_voltage;
			curr_q <= pv_current;
		end
		if (cmd.mul) power_q <= op_q ? 32'd0 : {16'b0, volt_q} * {16'b0, curr_q};
		if (cmd.spr_x) sx_q <= span_x;
		if (cmd.spr_q) sq_q <= recip_prod[PW-1:32];
		if (cmd.spr_wr) begin
			pos_q[cmd.idx] <= spr_pos;
			vel_q[cmd.idx] <= '0;
			pbest_pos_q[cmd.idx] <= spr_pos;
			pbest_fit_q[cmd.idx] <= mppo_pkg::FIT_NONE;
		end
		if (cmd.spr_fin) begin
			if (!cmd.warm) begin
				gbest_pos_q <= pos_q[0];
				gbest_fit_q <= mppo_pkg::FIT_NONE;
				track_down_q <= 1'b0;
			end
			pos_q[0] <= p0_new;
			pbest_pos_q[0] <= p0_new;
			ref_pow_q <= mppo_pkg::FIT_NONE;
			tprev_q <= mppo_pkg::FIT_NONE;
			tvref_q <= p0_new;
		end
		if (cmd.scan_eval) begin
			if (p_s > pbest_fit_q[pidx_q]) begin
				pbest_fit_q[pidx_q] <= p_s;
				pbest_pos_q[pidx_q] <= pos_q[pidx_q];
			end
			if (p_s > gbest_fit_q) begin
				gbest_fit_q <= p_s;
				gbest_pos_q <= pos_q[pidx_q];
			end
		end
		if (cmd.upd_a) begin
			t1_q <= t1;
			t2_q <= t2;
		end
		if (cmd.upd_b) begin
			vel_q[cmd.idx] <= vsat[14:0];
			pos_q[cmd.idx] <= upd_pos;
		end
		if (cmd.scan_chk && iter_done) begin
			ref_pow_q <= gbest_fit_q;
			tprev_q <= gbest_fit_q;
			track_down_q <= 1'b0;
			tvref_q <= gbest_pos_q;
		end
		if (cmd.track) begin
			if (p_s > gbest_fit_q) begin
				gbest_fit_q <= p_s;
				gbest_pos_q <= tvref_q;
				ref_pow_q <= p_s;
			end
			track_down_q <= track_down_n;
			tprev_q <= p_s;
			tvref_q <= tvref_n;
		end
		if (cmd.load_out) begin
			vref_q <= algo_q ? (in_track_q ? tvref_q : pos_q[pidx_q]) : po_vref_q;
			power_out_q <= power_q;
			phase_q <= algo_q ? (in_track_q ? mppo_pkg::PHASE_TRACK : mppo_pkg::PHASE_SCAN)
				: mppo_pkg::PHASE_PO;
		end
	end

	assign vref = vref_q;
	assign power = power_out_q;
	assign phase = phase_q;

endmodule

### design/mppo_ctrl.sv
`timescale 1ns / 1ps
`include "mppt_pso_and_perturb_observe_unit_defines.svh"
module mppo_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  mppo_pkg::dp_status_t status,
	output mppo_pkg::dp_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MUL     = 4'd1;
	localparam logic [3:0] ST_DISP    = 4'd2;
	localparam logic [3:0] ST_SPR_X   = 4'd3;
	localparam logic [3:0] ST_SPR_Q   = 4'd4;
	localparam logic [3:0] ST_SPR_W   = 4'd5;
	localparam logic [3:0] ST_SPR_FIN = 4'd6;
	localparam logic [3:0] ST_UPD_A   = 4'd7;
	localparam logic [3:0] ST_UPD_B   = 4'd8;
	localparam logic [3:0] ST_CHK     = 4'd9;
	localparam logic [3:0] ST_OUT     = 4'd10;

	logic [3:0] state_q, state_d;
	logic [mppo_pkg::PIDX_W-1:0] idx_q, idx_d;
	logic warm_q, warm_d;
	logic out_valid_q;
	logic idx_last;
	logic [13:0] cmd_pulses;

	assign idx_last = idx_q == mppo_pkg::LAST_IDX;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.warm = warm_q;
		state_d = state_q;
		idx_d = idx_q;
		warm_d = warm_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DISP;
			end
			ST_DISP: begin
				idx_d = '0;
				if (status.op) begin
					if (status.algo) begin
						warm_d = 1'b0;
						state_d = ST_SPR_X;
					end else begin
						cmd.po_restart = 1'b1;
						state_d = ST_OUT;
					end
				end else if (!status.algo) begin
					cmd.po_step = 1'b1;
					state_d = ST_OUT;
				end else if (!status.ready) begin
					warm_d = 1'b0;
					state_d = ST_SPR_X;
				end else if (status.in_track) begin
					if (status.drop) begin
						warm_d = 1'b1;
						state_d = ST_SPR_X;
					end else begin
						cmd.track = 1'b1;
						state_d = ST_OUT;
					end
				end else begin
					cmd.scan_eval = 1'b1;
					state_d = status.wrap ? ST_UPD_A : ST_CHK;
				end
			end
			ST_SPR_X: begin
				cmd.spr_x = 1'b1;
				state_d = ST_SPR_Q;
			end
			ST_SPR_Q: begin
				cmd.spr_q = 1'b1;
				state_d = ST_SPR_W;
			end
			ST_SPR_W: begin
				cmd.spr_wr = 1'b1;
				if (idx_last) begin
					state_d = ST_SPR_FIN;
				end else begin
					idx_d = idx_q + mppo_pkg::PIDX_W'(1);
					state_d = ST_SPR_X;
				end
			end
			ST_SPR_FIN: begin
				cmd.spr_fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_UPD_A: begin
				cmd.upd_a = 1'b1;
				state_d = ST_UPD_B;
			end
			ST_UPD_B: begin
				cmd.upd_b = 1'b1;
				if (idx_last) begin
					state_d = ST_CHK;
				end else begin
					idx_d = idx_q + mppo_pkg::PIDX_W'(1);
					state_d = ST_UPD_A;
				end
			end
			ST_CHK: begin
				cmd.scan_chk = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			warm_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			warm_q <= warm_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	assign cmd_pulses = {cmd.cap, cmd.mul, cmd.po_restart, cmd.po_step, cmd.spr_x,
		cmd.spr_q, cmd.spr_wr, cmd.spr_fin, cmd.scan_eval, cmd.upd_a, cmd.upd_b,
		cmd.scan_chk, cmd.track, cmd.load_out};

	`MPPO_ASSERT_NXT(a_accept_to_mul, in_valid && !in_stall, state_q == ST_MUL)
	`MPPO_ASSERT(a_cmd_single, $onehot0(cmd_pulses))
	`MPPO_ASSERT_IMP(a_no_overwrite, out_valid_q && out_stall, !cmd.load_out)

endmodule

### design/mppt_pso_and_perturb_observe_unit.sv
`timescale 1ns / 1ps
// channel   handshake             payload
// config    cfg_valid/cfg_ready   cfg_index[2:0], cfg_data[31:0]
// input     in_valid/in_stall     op, pv_voltage, pv_current
// output    out_valid/out_stall   vref, power, phase
//
// One item at a time. Perturb and observe and swarm track pass the capture,
// multiply, dispatch and output states; a swarm scan sample adds the check
// state, and first an update (UPD_A, UPD_B) of each particle when it closes
// a swarm iteration. A restart spreads the N particles (SPR_X, SPR_Q, SPR_W).
// Reset is asynchronous, active low; the first swarm sample after reset
// restarts the swarm. A stalled result stays in the output register while
// the next item is taken; the block then holds before writing its result.
module mppt_pso_and_perturb_observe_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] pv_voltage,
	input  logic [15:0] pv_current,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] vref,
	output logic [31:0] power,
	output logic [1:0]  phase
);

	mppo_pkg::dp_cmd_t    cmd;
	mppo_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	mppo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mppo_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.pv_voltage (pv_voltage),
		.pv_current (pv_current),
		.vref       (vref),
		.power      (power),
		.phase      (phase)
	);

endmodule
